// ===== src/dmsp_pkg.sv =====
`timescale 1ns / 1ps

package dmsp_pkg;

  typedef enum logic [1:0] {
    OP_CMD    = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_PWM    = 2'd2,
    OP_MS     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_RUN    = 2'd1,
    ST_LOOP   = 2'd2,
    ST_FINISH = 2'd3
  } seq_state_t;

  // configuration register indexes
  localparam logic [7:0] CFG_PWM_PERIOD = 8'd0;
  localparam logic [7:0] CFG_TIME_SCALE = 8'd1;
  localparam logic [7:0] CFG_HOLD_TICKS = 8'd2;
  localparam logic [7:0] CFG_LOOP_CODE  = 8'd3;

  localparam logic [9:0]  PWM_PERIOD_RST = 10'd100;
  localparam logic [7:0]  TIME_SCALE_RST = 8'd25;
  localparam logic [15:0] HOLD_TICKS_RST = 16'd1000;
  localparam logic [7:0]  LOOP_CODE_RST  = 8'd9;

  localparam logic [7:0]  SLOT_RUN_NOW = 8'hFF;
  localparam logic [10:0] PERIOD_MAX   = 11'd1024;
  localparam logic [6:0]  PCT_SCALE    = 7'd100;
  localparam logic [11:0] LEFT_OFFSET  = 12'd240;
  localparam logic [11:0] RIGHT_OFFSET = 12'd1900;

  // motion modes
  localparam logic [7:0] MODE_STOP    = 8'd0;
  localparam logic [7:0] MODE_P1      = 8'd1;
  localparam logic [7:0] MODE_P2      = 8'd2;
  localparam logic [7:0] MODE_LZ_NONE = 8'd3;
  localparam logic [7:0] MODE_LZ_P2   = 8'd4;
  localparam logic [7:0] MODE_LZ_P1   = 8'd5;
  localparam logic [7:0] MODE_RZ_NONE = 8'd6;
  localparam logic [7:0] MODE_NONE    = 8'd7;
  localparam logic [7:0] MODE_BOTH    = 8'd8;

  typedef struct packed {
    logic [15:0] hold_ticks;
    logic [9:0]  pwm_period;
    logic [7:0]  time_scale;
    logic [7:0]  loop_start_code;
  } cfg_t;

  // tdata layout, first field in the high bits
  typedef struct packed {
    logic [7:0]  battery_level;
    logic [15:0] left_current;
    logic [15:0] right_current;
    logic [7:0]  right_duty;
    logic [7:0]  left_duty;
    logic [7:0]  run_time;
    logic [7:0]  mode_code;
    logic [7:0]  step_slot;
  } item_t;

  typedef struct packed {
    opcode_t opcode;
    item_t   item;
  } stage_t;

  typedef struct packed {
    logic seq_busy;
    logic left_ok;
    logic right_ok;
    logic pwm_running;
    logic phase_two;
    logic phase_one;
    logic pwm_two;
    logic pwm_one;
  } result_t;

  typedef struct packed {
    logic [7:0] right_duty;
    logic [7:0] left_duty;
    logic [7:0] run_time;
    logic [7:0] mode;
  } step_t;

  typedef struct packed {
    logic stop;
    logic known;
    logic phase_one;
    logic phase_two;
    logic clr_left;
    logic clr_right;
  } mode_dec_t;

  function automatic mode_dec_t decode_mode(input logic [7:0] mode);
    mode_dec_t d;
    d = '0;
    unique case (mode)
      MODE_STOP:    d.stop = 1'b1;
      MODE_P1:      begin d.known = 1'b1; d.phase_one = 1'b1; end
      MODE_P2:      begin d.known = 1'b1; d.phase_two = 1'b1; end
      MODE_LZ_NONE: begin d.known = 1'b1; d.clr_left = 1'b1; end
      MODE_LZ_P2:   begin d.known = 1'b1; d.clr_left = 1'b1; d.phase_two = 1'b1; end
      MODE_LZ_P1:   begin d.known = 1'b1; d.clr_left = 1'b1; d.phase_one = 1'b1; end
      MODE_RZ_NONE: begin d.known = 1'b1; d.clr_right = 1'b1; end
      MODE_NONE:    d.known = 1'b1;
      MODE_BOTH:    begin d.known = 1'b1; d.phase_one = 1'b1; d.phase_two = 1'b1; end
      default:      d = '0;
    endcase
    return d;
  endfunction

endpackage

// ===== src/dmsp_cfg.sv =====
`timescale 1ns / 1ps

module dmsp_cfg
  import dmsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_period      <= PWM_PERIOD_RST;
      cfg_r.time_scale      <= TIME_SCALE_RST;
      cfg_r.hold_ticks      <= HOLD_TICKS_RST;
      cfg_r.loop_start_code <= LOOP_CODE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PWM_PERIOD: cfg_r.pwm_period      <= cfg_data[9:0];
        CFG_TIME_SCALE: cfg_r.time_scale      <= cfg_data[7:0];
        CFG_HOLD_TICKS: cfg_r.hold_ticks      <= cfg_data;
        CFG_LOOP_CODE:  cfg_r.loop_start_code <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/dmsp_in_reg.sv =====
`timescale 1ns / 1ps

module dmsp_in_reg
  import dmsp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  stage_t in_data,
  input  logic   take,
  output logic   valid,
  output stage_t data
);

  logic   valid_r;
  stage_t data_r;

  assign in_ready = !valid_r || take;
  assign valid    = valid_r;
  assign data     = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= in_data;
    end
  end

endmodule

// ===== src/dmsp_core.sv =====
`timescale 1ns / 1ps

module dmsp_core
  import dmsp_pkg::*;
#(
  parameter int TABLE_STEPS = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  stage_t  stage,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int IDX_W = (TABLE_STEPS > 1) ? $clog2(TABLE_STEPS) : 1;
  localparam logic [8:0]     TS_SLOT = 9'(TABLE_STEPS);
  localparam logic [IDX_W:0] TS_POS  = (IDX_W + 1)'(TABLE_STEPS);

  seq_state_t state_r, state_nxt;
  logic [7:0]  cur_mode_r, cur_mode_nxt;
  logic [7:0]  cur_time_r, cur_time_nxt;
  logic [7:0]  ldut_r, ldut_nxt;
  logic [7:0]  rdut_r, rdut_nxt;
  logic [7:0]  loop_count_r, loop_count_nxt;
  logic [IDX_W-1:0] loop_pos_r, loop_pos_nxt;
  logic [15:0] step_timer_r, step_timer_nxt;
  logic [15:0] rhold_r, rhold_nxt;
  logic [15:0] lhold_r, lhold_nxt;
  logic        rok_r, rok_nxt, lok_r, lok_nxt;
  logic [9:0]  pwm_count_r, pwm_count_nxt;
  logic        ph1_r, ph1_nxt, ph2_r, ph2_nxt, run_r, run_nxt;
  logic        pin1_r, pin1_nxt, pin2_r, pin2_nxt;

  step_t                  tbl [TABLE_STEPS];
  logic [TABLE_STEPS-1:0] tbl_vld_r;

  item_t       it;
  logic        cmd, cmd_run, cmd_loop, cmd_stop, cmd_wr, ms, adv, stop;
  logic [15:0] timer_dec;
  step_t       entry_r, wr_step;
  logic [7:0]  adv_mode, adv_time, adv_ld, adv_rd;
  mode_dec_t   md;
  logic [IDX_W:0] pos_inc;

  logic [11:0] l_lin, r_lin;
  logic [22:0] l_th, r_th, l_cur, r_cur, bat;
  logic [10:0] period, cnt_inc;
  logic [17:0] cnt_pct, l_lim, r_lim;

  assign it = stage.item;

  // event decode
  always_comb begin
    cmd       = fire && (stage.opcode == OP_CMD);
    ms        = fire && (stage.opcode == OP_MS);
    cmd_run   = cmd && (it.step_slot == SLOT_RUN_NOW);
    cmd_loop  = cmd && !cmd_run && (it.mode_code == cfg.loop_start_code);
    cmd_stop  = cmd && !cmd_run && !cmd_loop && (it.mode_code == MODE_STOP);
    cmd_wr    = cmd && !cmd_run && !cmd_loop && !cmd_stop
                && ({1'b0, it.step_slot} < TS_SLOT);
    wr_step   = '{right_duty: it.right_duty,
                  left_duty:  it.left_duty,
                  run_time:   it.run_time,
                  mode:       it.mode_code};
    timer_dec = step_timer_r - 16'(step_timer_r != 16'd0);
    adv       = ms && (state_r != ST_IDLE) && (timer_dec == 16'd0);
    adv_mode  = cur_mode_r;
    adv_time  = cur_time_r;
    adv_ld    = ldut_r;
    adv_rd    = rdut_r;
    if (state_r == ST_LOOP) begin
      adv_mode = entry_r.mode;
      adv_time = entry_r.run_time;
      adv_ld   = entry_r.left_duty;
      adv_rd   = entry_r.right_duty;
    end else if (state_r == ST_FINISH) begin
      adv_mode = MODE_STOP;
    end
    md      = decode_mode(adv_mode);
    stop    = cmd_stop || (adv && md.stop);
    pos_inc = {1'b0, loop_pos_r} + (IDX_W + 1)'(1);
  end

  // next sequencer state
  always_comb begin
    state_nxt = state_r;
    priority if (stop)                        state_nxt = ST_IDLE;
    else if (cmd_run)                         state_nxt = ST_RUN;
    else if (cmd_loop)                        state_nxt = ST_LOOP;
    else if (adv && (state_r == ST_RUN))      state_nxt = ST_FINISH;
    else                                      state_nxt = state_r;
  end

  // thresholds, kept in hundredths
  always_comb begin
    l_lin = 12'({ldut_r, 3'b000}) + LEFT_OFFSET;
    r_lin = 12'({rdut_r, 3'b000}) + RIGHT_OFFSET;
    bat   = 23'(it.battery_level) * 23'(PCT_SCALE);
    l_th  = 23'(ldut_r) * 23'(l_lin) + bat;
    r_th  = 23'(rdut_r) * 23'(r_lin) + bat;
    l_cur = 23'(it.left_current) * 23'(PCT_SCALE);
    r_cur = 23'(it.right_current) * 23'(PCT_SCALE);
  end

  // pwm period counter and compare
  always_comb begin
    period  = (cfg.pwm_period == 10'd0) ? PERIOD_MAX : {1'b0, cfg.pwm_period};
    cnt_inc = {1'b0, pwm_count_r} + 11'd1;
    cnt_pct = 18'(cnt_inc == period ? 10'd0 : cnt_inc[9:0]) * 18'(PCT_SCALE);
    l_lim   = 18'(ldut_r) * 18'(period);
    r_lim   = 18'(rdut_r) * 18'(period);
  end

  // datapath update
  always_comb begin
    cur_mode_nxt   = cur_mode_r;
    cur_time_nxt   = cur_time_r;
    ldut_nxt       = ldut_r;
    rdut_nxt       = rdut_r;
    loop_count_nxt = loop_count_r;
    loop_pos_nxt   = loop_pos_r;
    step_timer_nxt = step_timer_r;
    rhold_nxt      = rhold_r;
    lhold_nxt      = lhold_r;
    rok_nxt        = rok_r;
    lok_nxt        = lok_r;
    pwm_count_nxt  = pwm_count_r;
    ph1_nxt        = ph1_r;
    ph2_nxt        = ph2_r;
    run_nxt        = run_r;
    pin1_nxt       = pin1_r;
    pin2_nxt       = pin2_r;

    if (cmd_run) begin
      cur_mode_nxt = it.mode_code;
      cur_time_nxt = it.run_time;
      ldut_nxt     = it.left_duty;
      rdut_nxt     = it.right_duty;
    end
    if (cmd_loop) begin
      loop_count_nxt = it.step_slot;
    end

    if (fire && (stage.opcode == OP_SAMPLE)) begin
      if (r_cur > r_th) begin
        rok_nxt   = 1'b0;
        rhold_nxt = cfg.hold_ticks;
      end else if (rhold_r == 16'd0) begin
        rok_nxt = 1'b1;
      end
      if (l_cur > l_th) begin
        lok_nxt   = 1'b0;
        lhold_nxt = cfg.hold_ticks;
      end else if (lhold_r == 16'd0) begin
        lok_nxt = 1'b1;
      end
    end

    if (fire && (stage.opcode == OP_PWM) && run_r) begin
      pwm_count_nxt = (cnt_inc == period) ? 10'd0 : cnt_inc[9:0];
      pin1_nxt      = (cnt_pct < l_lim) && rok_r;
      pin2_nxt      = (cnt_pct < r_lim) && lok_r;
    end

    if (ms) begin
      step_timer_nxt = timer_dec;
      rhold_nxt      = rhold_r - 16'(rhold_r != 16'd0);
      lhold_nxt      = lhold_r - 16'(lhold_r != 16'd0);
    end

    if (adv) begin
      cur_mode_nxt = adv_mode;
      cur_time_nxt = adv_time;
      ldut_nxt     = md.clr_left ? 8'd0 : adv_ld;
      rdut_nxt     = md.clr_right ? 8'd0 : adv_rd;
      if (state_r == ST_LOOP) begin
        loop_pos_nxt = ((9'(pos_inc) == {1'b0, loop_count_r}) || pos_inc >= TS_POS)
                       ? '0 : pos_inc[IDX_W-1:0];
      end
      if (md.known) begin
        ph1_nxt = md.phase_one;
        ph2_nxt = md.phase_two;
        run_nxt = 1'b1;
      end
      step_timer_nxt = 16'(adv_time) * 16'(cfg.time_scale);
    end

    if (stop) begin
      cur_mode_nxt   = MODE_STOP;
      cur_time_nxt   = 8'd0;
      ldut_nxt       = 8'd0;
      rdut_nxt       = 8'd0;
      loop_count_nxt = 8'd0;
      loop_pos_nxt   = '0;
      step_timer_nxt = 16'd0;
      ph1_nxt        = 1'b0;
      ph2_nxt        = 1'b0;
      run_nxt        = 1'b0;
      pin1_nxt       = 1'b0;
      pin2_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cur_mode_r   <= 8'd0;
      cur_time_r   <= 8'd0;
      ldut_r       <= 8'd0;
      rdut_r       <= 8'd0;
      loop_count_r <= 8'd0;
      loop_pos_r   <= '0;
      step_timer_r <= 16'd0;
      rhold_r      <= 16'd0;
      lhold_r      <= 16'd0;
      rok_r        <= 1'b0;
      lok_r        <= 1'b0;
      pwm_count_r  <= 10'd0;
      ph1_r        <= 1'b0;
      ph2_r        <= 1'b0;
      run_r        <= 1'b0;
      pin1_r       <= 1'b0;
      pin2_r       <= 1'b0;
      tbl_vld_r    <= '0;
      entry_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      cur_mode_r   <= cur_mode_nxt;
      cur_time_r   <= cur_time_nxt;
      ldut_r       <= ldut_nxt;
      rdut_r       <= rdut_nxt;
      loop_count_r <= loop_count_nxt;
      loop_pos_r   <= loop_pos_nxt;
      step_timer_r <= step_timer_nxt;
      rhold_r      <= rhold_nxt;
      lhold_r      <= lhold_nxt;
      rok_r        <= rok_nxt;
      lok_r        <= lok_nxt;
      pwm_count_r  <= pwm_count_nxt;
      ph1_r        <= ph1_nxt;
      ph2_r        <= ph2_nxt;
      run_r        <= run_nxt;
      pin1_r       <= pin1_nxt;
      pin2_r       <= pin2_nxt;
      // stop wipes the table by dropping every valid bit
      if (stop) begin
        tbl_vld_r <= '0;
      end else if (cmd_wr) begin
        tbl_vld_r[it.step_slot[IDX_W-1:0]] <= 1'b1;
      end
      // entry at the next loop position, registered from loop_pos_nxt
      if (stop) begin
        entry_r <= '0;
      end else if (cmd_wr && (it.step_slot[IDX_W-1:0] == loop_pos_nxt)) begin
        entry_r <= wr_step;
      end else begin
        entry_r <= tbl_vld_r[loop_pos_nxt] ? tbl[loop_pos_nxt] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_wr) begin
      tbl[it.step_slot[IDX_W-1:0]] <= wr_step;
    end
  end

  always_comb begin
    result.pwm_one     = pin1_nxt;
    result.pwm_two     = pin2_nxt;
    result.phase_one   = ph1_nxt;
    result.phase_two   = ph2_nxt;
    result.pwm_running = run_nxt;
    result.right_ok    = rok_nxt;
    result.left_ok     = lok_nxt;
    result.seq_busy    = (state_nxt != ST_IDLE);
  end

endmodule

// ===== src/dmsp_out_reg.sv =====
`timescale 1ns / 1ps

module dmsp_out_reg
  import dmsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t load_data,
  output logic    free,
  output logic    out_tvalid,
  input  logic    out_tready,
  output result_t out_data
);

  logic    valid_r;
  result_t data_r;

  assign free       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_data   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

// ===== src/dual_motor_step_sequencer_pwm.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// in_      slave      in_tvalid/in_tready   tuser opcode, tdata item fields
// out_     master     out_tvalid/out_tready tdata pin and flag levels
// cfg_     slave      cfg_valid/cfg_ready   cfg_index register, cfg_data value
//
// One item per cycle sustained while out_tready is high; each item's result
// reaches out_tdata through the input register, then the result register.
// The rate is set by the combinational state update between the two registers.
// rst_n is synchronous; reset clears all state and restores register defaults.
// A stalled result holds in the result register; one more item waits in the
// input register, then in_tready drops. cfg_ready is always high.

module dual_motor_step_sequencer_pwm
  import dmsp_pkg::*;
#(
  parameter int TABLE_STEPS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] step_slot, [15:8] mode_code, [23:16] run_time, [31:24] left_duty,
  // [39:32] right_duty, [55:40] right_current, [71:56] left_current,
  // [79:72] battery_level
  input  logic [79:0] in_tdata,
  // [1:0] opcode
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] pwm_one, [1] pwm_two, [2] phase_one, [3] phase_two, [4] pwm_running,
  // [5] right_ok, [6] left_ok, [7] seq_busy
  output logic [7:0]  out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  stage_t  in_word, stage;
  logic    stage_valid, out_free, fire;
  result_t result, out_word;

  assign in_word.opcode = opcode_t'(in_tuser);
  assign in_word.item   = item_t'(in_tdata);
  assign fire           = stage_valid && out_free;
  assign out_tdata      = 8'(out_word);

  dmsp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dmsp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_word),
    .take     (fire),
    .valid    (stage_valid),
    .data     (stage)
  );

  dmsp_core #(
    .TABLE_STEPS (TABLE_STEPS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .stage  (stage),
    .cfg    (cfg),
    .result (result)
  );

  dmsp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .load_data  (result),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (out_word)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import dmsp_pkg::*;

  localparam int DEPTH = 32;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  dual_motor_step_sequencer_pwm dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------- motor controller predictor ----------------
  logic [9:0]  period_reg;
  logic [7:0]  scale_reg;
  logic [15:0] hold_reg;
  logic [7:0]  loop_code_reg;

  seq_state_t  seq;
  step_t       steps [DEPTH];
  logic [7:0]  mode_now, time_now, duty_l, duty_r, loop_len, loop_idx;
  logic [15:0] step_left, hold_r, hold_l;
  logic        ok_r, ok_l;
  logic [9:0]  pwm_pos;
  logic        phase1, phase2, pwm_on, pin_one, pin_two;

  function automatic void halt_motors();
    pwm_on = 1'b0;
    pin_one = 1'b0;
    pin_two = 1'b0;
    phase1 = 1'b0;
    phase2 = 1'b0;
    seq = ST_IDLE;
    step_left = '0;
    mode_now = '0;
    time_now = '0;
    duty_l = '0;
    duty_r = '0;
    loop_len = '0;
    loop_idx = '0;
    foreach (steps[i]) steps[i] = '0;
  endfunction

  function automatic void reset_motors();
    period_reg = PWM_PERIOD_RST;
    scale_reg = TIME_SCALE_RST;
    hold_reg = HOLD_TICKS_RST;
    loop_code_reg = LOOP_CODE_RST;
    halt_motors();
    hold_r = '0;
    hold_l = '0;
    ok_r = 1'b0;
    ok_l = 1'b0;
    pwm_pos = '0;
  endfunction

  function automatic void drive_phases(input logic p1, input logic p2);
    phase1 = p1;
    phase2 = p2;
    pwm_on = 1'b1;
  endfunction

  function automatic void apply_mode();
    case (mode_now)
      MODE_STOP:    halt_motors();
      MODE_P1:      drive_phases(1'b1, 1'b0);
      MODE_P2:      drive_phases(1'b0, 1'b1);
      MODE_LZ_NONE: begin duty_l = '0; drive_phases(1'b0, 1'b0); end
      MODE_LZ_P2:   begin duty_l = '0; drive_phases(1'b0, 1'b1); end
      MODE_LZ_P1:   begin duty_l = '0; drive_phases(1'b1, 1'b0); end
      MODE_RZ_NONE: begin duty_r = '0; drive_phases(1'b0, 1'b0); end
      MODE_NONE:    drive_phases(1'b0, 1'b0);
      MODE_BOTH:    drive_phases(1'b1, 1'b1);
      default:      ;
    endcase
  endfunction

  function automatic void run_command(input item_t it);
    if (it.step_slot == SLOT_RUN_NOW) begin
      time_now = it.run_time;
      duty_l = it.left_duty;
      duty_r = it.right_duty;
      mode_now = it.mode_code;
      seq = ST_RUN;
    end else if (it.mode_code == loop_code_reg) begin
      loop_len = it.step_slot;
      seq = ST_LOOP;
    end else if (it.mode_code == MODE_STOP) begin
      halt_motors();
    end else if (it.step_slot < DEPTH) begin
      steps[it.step_slot] = {it.right_duty, it.left_duty, it.run_time, it.mode_code};
    end
  endfunction

  // thresholds are in hundredths, so the currents are scaled up to match
  function automatic void take_sample(input item_t it);
    int unsigned r_amp, l_amp, batt, dl, dr, l_lim, r_lim;
    r_amp = it.right_current;
    l_amp = it.left_current;
    batt = it.battery_level;
    dl = duty_l;
    dr = duty_r;
    r_amp = r_amp * PCT_SCALE;
    l_amp = l_amp * PCT_SCALE;
    batt = batt * PCT_SCALE;
    l_lim = dl * (8 * dl + LEFT_OFFSET) + batt;
    r_lim = dr * (8 * dr + RIGHT_OFFSET) + batt;
    if (r_amp > r_lim) begin
      ok_r = 1'b0;
      hold_r = hold_reg;
    end else if (hold_r == 0) begin
      ok_r = 1'b1;
    end
    if (l_amp > l_lim) begin
      ok_l = 1'b0;
      hold_l = hold_reg;
    end else if (hold_l == 0) begin
      ok_l = 1'b1;
    end
  endfunction

  function automatic void pwm_tick();
    int unsigned per, nxt, pos100, lim_l, lim_r;
    if (pwm_on) begin
      per = (period_reg == 0) ? PERIOD_MAX : period_reg;
      nxt = pwm_pos;
      nxt = nxt + 1;
      pwm_pos = (nxt == per) ? 10'd0 : 10'(nxt);
      pos100 = pwm_pos;
      pos100 = pos100 * PCT_SCALE;
      lim_l = duty_l;
      lim_r = duty_r;
      lim_l = lim_l * per;
      lim_r = lim_r * per;
      pin_one = (pos100 < lim_l) && ok_r;
      pin_two = (pos100 < lim_r) && ok_l;
    end
  endfunction

  function automatic void ms_tick();
    step_t       e;
    int unsigned nxt, span;
    if (step_left != 0) step_left--;
    if (hold_r != 0) hold_r--;
    if (hold_l != 0) hold_l--;
    if (seq != ST_IDLE && step_left == 0) begin
      if (seq == ST_LOOP) begin
        e = (loop_idx < DEPTH) ? steps[loop_idx] : '0;
        mode_now = e.mode;
        time_now = e.run_time;
        duty_l = e.left_duty;
        duty_r = e.right_duty;
        nxt = loop_idx;
        nxt = nxt + 1;
        loop_idx = (nxt == loop_len || nxt >= DEPTH) ? 8'd0 : 8'(nxt);
      end else if (seq == ST_FINISH) begin
        mode_now = MODE_STOP;
      end else begin
        seq = ST_FINISH;
      end
      apply_mode();
      span = time_now;
      span = span * scale_reg;
      step_left = 16'(span);
    end
  endfunction

  function automatic result_t step_motors(input opcode_t op, input item_t it);
    result_t r;
    case (op)
      OP_CMD:    run_command(it);
      OP_SAMPLE: take_sample(it);
      OP_PWM:    pwm_tick();
      default:   ms_tick();
    endcase
    r.pwm_one = pin_one;
    r.pwm_two = pin_two;
    r.phase_one = phase1;
    r.phase_two = phase2;
    r.pwm_running = pwm_on;
    r.right_ok = ok_r;
    r.left_ok = ok_l;
    r.seq_busy = (seq != ST_IDLE);
    return r;
  endfunction

  // ---------------- driver, receiver, checker ----------------
  stage_t  pending [$];
  result_t pin_levels_due [$];
  stage_t  next_item;
  result_t want, got;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      mismatches = 0;
  int      checked = 0;
  int      op_count [4] = '{0, 0, 0, 0};
  string   level_name [8] = '{"pwm_one", "pwm_two", "phase_one", "phase_two",
                              "pwm_running", "right_ok", "left_ok", "seq_busy"};

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        pin_levels_due.push_back(step_motors(opcode_t'(in_tuser), item_t'(in_tdata)));
        op_count[in_tuser]++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_item = pending.pop_front();
          in_tuser <= next_item.opcode;
          in_tdata <= next_item.item;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PWM_PERIOD: period_reg = cfg_data[9:0];
        CFG_TIME_SCALE: scale_reg = cfg_data[7:0];
        CFG_HOLD_TICKS: hold_reg = cfg_data;
        CFG_LOOP_CODE:  loop_code_reg = cfg_data[7:0];
        default:        ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pin_levels_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %b", $time, got);
        mismatches++;
      end else begin
        want = pin_levels_due.pop_front();
        checked++;
        for (int i = 0; i < 8; i++) begin
          if (got[i] !== want[i]) begin
            $display("%0t: %s expected %b got %b", $time, level_name[i], want[i], got[i]);
            mismatches++;
          end
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic stage_t scramble_item();
    stage_t s;
    s.opcode = opcode_t'($urandom_range(0, 3));
    s.item = 80'({$urandom(), $urandom(), $urandom()});
    return s;
  endfunction

  function automatic stage_t mk_cmd(input logic [7:0] slot, input logic [7:0] mode,
                                    input logic [7:0] rt, input logic [7:0] ld,
                                    input logic [7:0] rd);
    stage_t s;
    s = scramble_item();
    s.opcode = OP_CMD;
    s.item.step_slot = slot;
    s.item.mode_code = mode;
    s.item.run_time = rt;
    s.item.left_duty = ld;
    s.item.right_duty = rd;
    return s;
  endfunction

  function automatic stage_t mk_tick(input opcode_t op);
    stage_t s;
    s = scramble_item();
    s.opcode = op;
    return s;
  endfunction

  function automatic stage_t mk_sample(input logic [15:0] rc, input logic [15:0] lc,
                                       input logic [7:0] bat);
    stage_t s;
    s = mk_tick(OP_SAMPLE);
    s.item.right_current = rc;
    s.item.left_current = lc;
    s.item.battery_level = bat;
    return s;
  endfunction

  function automatic int unsigned pick_duty();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 100) : $urandom_range(0, 255);
  endfunction

  // mostly near the thresholds, with the full range now and then
  function automatic int unsigned pick_amp();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 400);
    if (r < 8) return $urandom_range(0, 3000);
    if (r == 8) return $urandom_range(0, 1) ? 65535 : 0;
    return $urandom_range(0, 65535);
  endfunction

  function automatic int unsigned pick_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return $urandom_range(MODE_P1, MODE_BOTH);
    if (r == 8) return MODE_STOP;
    return $urandom_range(0, 255);
  endfunction

  function automatic int unsigned pick_time();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(0, 255);
  endfunction

  function automatic void add_ticks(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) pending.push_back(mk_tick(OP_MS));
      else if (r < 85) pending.push_back(mk_tick(OP_PWM));
      else pending.push_back(mk_sample(16'(pick_amp()), 16'(pick_amp()),
                                       8'($urandom_range(0, 255))));
    end
  endfunction

  // episodes: table programs played in a loop, single timed moves, stray
  // table writes and plain noise
  function automatic void fill_phase(input int n_items);
    int kind, k, len;
    while (pending.size() < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++)
          pending.push_back(mk_cmd(8'(i), 8'(pick_mode()), 8'(pick_time()),
                                   8'(pick_duty()), 8'(pick_duty())));
        len = ($urandom_range(0, 3) == 0) ? 0 : k;
        pending.push_back(mk_cmd(8'(len), loop_code_reg, 8'($urandom), 8'($urandom),
                                 8'($urandom)));
        add_ticks($urandom_range(8, 30));
        if ($urandom_range(0, 2) == 0)
          pending.push_back(mk_cmd(8'($urandom_range(0, 254)), MODE_STOP, 8'($urandom),
                                   8'($urandom), 8'($urandom)));
      end else if (kind < 7) begin
        pending.push_back(mk_cmd(SLOT_RUN_NOW, 8'(pick_mode()), 8'(pick_time()),
                                 8'(pick_duty()), 8'(pick_duty())));
        add_ticks($urandom_range(5, 20));
      end else if (kind == 7) begin
        pending.push_back(mk_cmd(8'($urandom_range(0, 254)), 8'(pick_mode()),
                                 8'(pick_time()), 8'(pick_duty()), 8'(pick_duty())));
        add_ticks($urandom_range(1, 5));
      end else begin
        k = $urandom_range(3, 8);
        for (int i = 0; i < k; i++) pending.push_back(scramble_item());
      end
    end
  endfunction

  task automatic drain();
    while (pending.size() != 0 || in_tvalid || pin_levels_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_send(input logic [7:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input logic [15:0] per, input logic [15:0] scl,
                              input logic [15:0] hld, input logic [15:0] code);
    cfg_send(CFG_PWM_PERIOD, per);
    cfg_send(CFG_TIME_SCALE, scl);
    cfg_send(CFG_HOLD_TICKS, hld);
    cfg_send(CFG_LOOP_CODE, code);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    reset_motors();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 15;
    recv_idle_pct = 71;

    // directed: register defaults
    pending.push_back(mk_sample(16'd0, 16'd0, 8'd0));
    pending.push_back(mk_tick(OP_PWM));                        // pwm tick while stopped
    pending.push_back(mk_cmd(8'd0, MODE_P1, 8'd0, 8'd255, 8'd255));
    pending.push_back(mk_cmd(8'd1, MODE_LZ_NONE, 8'd0, 8'd40, 8'd60));
    pending.push_back(mk_cmd(8'd2, 8'd200, 8'd0, 8'd0, 8'd0));  // unknown mode
    pending.push_back(mk_cmd(8'd32, MODE_P2, 8'd1, 8'd1, 8'd1)); // past the table
    pending.push_back(mk_cmd(8'd254, MODE_BOTH, 8'd1, 8'd1, 8'd1));
    pending.push_back(mk_cmd(8'd3, LOOP_CODE_RST, 8'd0, 8'd0, 8'd0));
    pending.push_back(mk_tick(OP_MS));
    pending.push_back(mk_tick(OP_PWM));
    pending.push_back(mk_tick(OP_MS));
    pending.push_back(mk_tick(OP_MS));
    pending.push_back(mk_tick(OP_MS));                         // loop wraps to step 0
    pending.push_back(mk_tick(OP_PWM));
    pending.push_back(mk_sample(16'hFFFF, 16'hFFFF, 8'd255));
    pending.push_back(mk_tick(OP_PWM));
    pending.push_back(mk_cmd(SLOT_RUN_NOW, MODE_BOTH, 8'd0, 8'd0, 8'd255));
    pending.push_back(mk_tick(OP_MS));
    pending.push_back(mk_cmd(SLOT_RUN_NOW, MODE_RZ_NONE, 8'd1, 8'd100, 8'd100));
    pending.push_back(mk_tick(OP_MS));
    pending.push_back(mk_cmd(8'd7, MODE_STOP, 8'd0, 8'd0, 8'd0));
    pending.push_back(mk_cmd(SLOT_RUN_NOW, MODE_LZ_P2, 8'd0, 8'd10, 8'd20));
    pending.push_back(mk_tick(OP_MS));
    pending.push_back(mk_cmd(SLOT_RUN_NOW, MODE_LZ_P1, 8'd0, 8'd30, 8'd40));
    pending.push_back(mk_tick(OP_MS));
    drain();

    program_regs(16'd1, 16'd1, 16'd1, 16'd255);
    fill_phase(520);
    drain();

    send_idle_pct = 71;
    recv_idle_pct = 15;
    program_regs(16'd1023, 16'd255, 16'd65535, 16'd9);
    fill_phase(520);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(16'd7, 16'd3, 16'd20, 16'd100);
    fill_phase(280);
    drain();

    // a zero period counts as the full 1024 ticks
    program_regs(16'd0, 16'd2, 16'd300, 16'd9);
    fill_phase(280);
    drain();
    repeat (8) @(negedge clk);

    $display("Checked %0d results across 5 register settings and 3 flow control mixes",
             checked);
    $display("Items: %0d commands, %0d current samples, %0d pwm ticks, %0d ms ticks",
             op_count[OP_CMD], op_count[OP_SAMPLE], op_count[OP_PWM], op_count[OP_MS]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timeout waiting for results");
    $display("Mismatches found");
    $finish;
  end

endmodule
